FILE: rtl/emrb_pkg.sv
`default_nettype none

package emrb_pkg;

    // Width of the ring position fields that are reported on the result channel.
    localparam int unsigned POS_W = 10;

    // Command codes of an input item.
    localparam logic [1:0] CMD_HEADER = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_DISCARD = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    // One input item.
    typedef struct packed {
        logic [1:0]       cmd;
        logic [15:0]      msg_len;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] read_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       read_data;
        logic [POS_W-1:0] head_pos;
        logic [POS_W-1:0] tail_pos;
        logic [POS_W-1:0] fill_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic latch_in;
        logic dec_reject;
        logic dec_discard;
        logic store;
        logic set_top;
        logic pad_wr;
        logic start_evict;
        logic ev1_step;
        logic ev2_step;
        logic set_tail;
        logic finish_hdr;
        logic mod_sub;
        logic rd_issue;
        logic rd_latch;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       p_last;
        logic       hdr_reject;
        logic       hdr_wrap;
        logic       left_zero;
        logic       need_evict;
        logic       s1_done;
        logic       s2_go;
        logic       ridx_big;
        logic       out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/emrb_if.sv
`default_nettype none

// Input channel: valid, ready and one input item.
interface emrb_in_if import emrb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: valid, ready and one result item.
interface emrb_out_if import emrb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/emrb_datapath.sv
`default_nettype none

module emrb_datapath import emrb_pkg::*; #(
    parameter int unsigned RING_BYTES = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    localparam int unsigned AW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int unsigned FW = AW + 2;
    localparam logic [AW-1:0] P_LAST    = AW'(RING_BYTES - 1);
    localparam logic [16:0]   RB_17     = 17'(RING_BYTES);
    localparam logic [AW:0]   RB_A      = (AW+1)'(RING_BYTES);
    localparam logic [FW:0]   RB_F      = (FW+1)'(RING_BYTES);
    localparam logic [AW:0]   STEP_LAST = (AW+1)'(RING_BYTES - 1);

    // Byte ring, cleared by the controller after reset.
    logic [7:0] mem [RING_BYTES];

    // Latched input item.
    logic [1:0]       r_cmd;
    logic [15:0]      r_len;
    logic [7:0]       r_dbyte;
    logic [POS_W-1:0] r_ridx;

    // Ring state and walk registers.
    logic [AW-1:0] r_head, r_tail, r_top, r_wptr, r_p;
    logic [AW-1:0] r_left;
    logic [FW-1:0] r_fill;
    logic [AW:0]   r_steps;
    logic [7:0]    r_q;
    logic [7:0]    r_rdata;
    logic [2:0]    r_status;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic [AW-1:0] len_a, p_next, wptr_next, rd_addr, wr_addr, ridx_addr;
    logic [FW-1:0] fill_dec;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic [31:0]   ridx_32, head_32, tail_32, fill_32;

    // Decode of the latched item and the walk conditions.
    always_comb begin
        len_a     = r_len[AW-1:0];
        p_next    = (r_p == P_LAST) ? '0 : r_p + 1'b1;
        wptr_next = (r_wptr == P_LAST) ? '0 : r_wptr + 1'b1;
        fill_dec  = (r_fill == '0) ? '0 : r_fill - 1'b1;
        ridx_32   = 32'(r_ridx);
        ridx_addr = ridx_32[AW-1:0];
        head_32   = 32'(r_head);
        tail_32   = 32'(r_tail);
        fill_32   = 32'(r_fill);

        o_sts.cmd        = r_cmd;
        o_sts.p_last     = (r_p == P_LAST);
        o_sts.hdr_reject = (r_len <= 16'd1) || ({1'b0, r_len} >= RB_17);
        o_sts.hdr_wrap   = ((AW+1)'(r_head) + (AW+1)'(len_a)) >= RB_A;
        o_sts.left_zero  = (r_left == '0);
        o_sts.need_evict = ((FW+1)'(r_fill) + (FW+1)'(len_a)) >= RB_F;
        o_sts.s1_done    = (r_q == 8'd0) || (r_steps == STEP_LAST);
        o_sts.s2_go      = (r_q == 8'd0) && (r_steps < RB_A);
        o_sts.ridx_big   = ({7'b0, r_ridx} >= RB_17);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Memory port selection.
    always_comb begin
        wr_en   = i_cmd.clear_wr || i_cmd.pad_wr || i_cmd.store;
        wr_addr = i_cmd.store ? r_wptr : r_p;
        wr_data = i_cmd.store ? r_dbyte : 8'd0;
        rd_addr = i_cmd.rd_issue ? ridx_addr : r_p;
    end

    // Ring memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_q <= mem[rd_addr];
    end

    // Latched item and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd   <= i_in_item.cmd;
            r_len   <= i_in_item.msg_len;
            r_dbyte <= i_in_item.data_byte;
            r_ridx  <= i_in_item.read_index;
        end else if (i_cmd.mod_sub) begin
            r_ridx <= POS_W'({7'b0, r_ridx} - RB_17);
        end
        if (i_cmd.set_top) begin
            r_top <= r_head;
        end else if (i_cmd.pad_wr && (r_p == P_LAST)) begin
            r_top <= '0;
        end
        if (i_cmd.rd_latch) begin
            r_rdata <= r_q;
        end
        if (i_cmd.dec_reject) begin
            r_status <= ST_REJECT;
        end else if (i_cmd.dec_discard) begin
            r_status <= ST_DISCARD;
        end else if (i_cmd.store) begin
            r_status <= ST_STORED;
        end else if (i_cmd.finish_hdr) begin
            r_status <= ST_ACCEPT;
        end else if (i_cmd.rd_latch) begin
            r_status <= ST_READ;
        end
    end

    // Ring pointers, fill count and walk counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_wptr  <= '0;
            r_p     <= '0;
            r_left  <= '0;
            r_fill  <= '0;
            r_steps <= '0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_p <= p_next;
            end
            if (i_cmd.dec_reject) begin
                r_left <= '0;
            end
            if (i_cmd.store) begin
                r_wptr <= wptr_next;
                r_head <= wptr_next;
                r_fill <= r_fill + 1'b1;
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.set_top) begin
                r_p <= r_head;
            end
            if (i_cmd.pad_wr) begin
                r_p    <= p_next;
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.start_evict) begin
                r_p     <= r_tail;
                r_steps <= '0;
            end
            // First phase: walk through the oldest message up to its terminator.
            if (i_cmd.ev1_step) begin
                r_p     <= p_next;
                r_fill  <= fill_dec;
                r_steps <= o_sts.s1_done ? '0 : r_steps + 1'b1;
            end
            // Second phase: skip the NUL padding that follows.
            if (i_cmd.ev2_step) begin
                r_p     <= p_next;
                r_fill  <= fill_dec;
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.set_tail) begin
                r_tail <= r_p;
            end
            if (i_cmd.finish_hdr) begin
                r_head <= r_top;
                r_wptr <= r_top;
                r_left <= len_a;
            end
        end
    end

    // Result register, free again once the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status     <= r_status;
            r_out.read_data  <= (r_status == ST_READ) ? r_rdata : 8'd0;
            r_out.head_pos   <= head_32[POS_W-1:0];
            r_out.tail_pos   <= tail_32[POS_W-1:0];
            r_out.fill_count <= fill_32[POS_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A new result never overwrites one that the receiver has not taken.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");

    // An accepted message always fits beside the retained bytes.
    a_hdr_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish_hdr |=> (((FW+1)'(r_fill) + (FW+1)'(r_left)) < RB_F))
        else $error("accepted message does not fit in the ring");

    // Each stored byte uses up one expected byte.
    a_store_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |=> (r_left == $past(r_left) - 1'b1))
        else $error("byte count not decremented on store");

    // The walk pointer stays inside the ring.
    a_p_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_p) < RING_BYTES)
        else $error("walk pointer outside the ring");

endmodule

`default_nettype wire

FILE: rtl/emrb_ctrl.sv
`default_nettype none

module emrb_ctrl import emrb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_PAD    = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_S1_RD  = 4'd5;
    localparam logic [3:0] S_S1_EV  = 4'd6;
    localparam logic [3:0] S_S2_RD  = 4'd7;
    localparam logic [3:0] S_S2_EV  = 4'd8;
    localparam logic [3:0] S_MOD    = 4'd9;
    localparam logic [3:0] S_RD_GET = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.p_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_HEADER: begin
                        if (i_sts.hdr_reject) begin
                            o_cmd.dec_reject = 1'b1;
                            n_state          = S_EMIT;
                        end else begin
                            o_cmd.set_top = 1'b1;
                            n_state       = i_sts.hdr_wrap ? S_PAD : S_CHECK;
                        end
                    end
                    CMD_DATA: begin
                        if (i_sts.left_zero) begin
                            o_cmd.dec_discard = 1'b1;
                        end else begin
                            o_cmd.store = 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                    CMD_READ: begin
                        n_state = S_MOD;
                    end
                    default: begin
                        o_cmd.dec_discard = 1'b1;
                        n_state           = S_EMIT;
                    end
                endcase
            end
            // Zero the ring from the old head to its last byte.
            S_PAD: begin
                o_cmd.pad_wr = 1'b1;
                if (i_sts.p_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_evict) begin
                    o_cmd.start_evict = 1'b1;
                    n_state           = S_S1_RD;
                end else begin
                    o_cmd.finish_hdr = 1'b1;
                    n_state          = S_EMIT;
                end
            end
            S_S1_RD: begin
                n_state = S_S1_EV;
            end
            S_S1_EV: begin
                o_cmd.ev1_step = 1'b1;
                n_state        = i_sts.s1_done ? S_S2_RD : S_S1_RD;
            end
            S_S2_RD: begin
                n_state = S_S2_EV;
            end
            S_S2_EV: begin
                if (i_sts.s2_go) begin
                    o_cmd.ev2_step = 1'b1;
                    n_state        = S_S2_RD;
                end else begin
                    o_cmd.set_tail = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            // Reduce the read position into the ring, then read it.
            S_MOD: begin
                if (i_sts.ridx_big) begin
                    o_cmd.mod_sub = 1'b1;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RD_GET;
                end
            end
            S_RD_GET: begin
                o_cmd.rd_latch = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/evicting_message_ring_buffer.sv
`default_nettype none

// Ring of NUL-terminated messages with eviction of the oldest ones.
// Input channel i_in carries one command item: a message header with its
// length, one message data byte, or a read of a stored ring byte. The
// result channel o_out returns exactly one item per input item, with the
// status, the byte read, and the head, tail and fill count after the command.
// Each item is processed up to its result before the next is accepted. A read
// first subtracts RING_BYTES from the index until it lies inside the ring.
// An accepted header zeroes the bytes from the head to the end of the ring
// when the message would wrap, then evicts the oldest messages until it fits;
// the memory is read once per walked byte and the read data is registered.
// After reset the ring is cleared one byte per cycle, and no item is
// accepted during that pass.
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and processed, and the block waits only when
// that item's result is ready and the register is still full.
module evicting_message_ring_buffer import emrb_pkg::*; #(
    parameter int unsigned RING_BYTES = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    emrb_in_if.sink     i_in,
    emrb_out_if.source  o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer for headers, eviction walks and reads.
    emrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Ring memory, pointers and result register.
    emrb_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_item   (i_in.payload),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.payload)
    );

endmodule

`default_nettype wire

FILE: bench/evicting_message_ring_buffer_tb.sv
`timescale 1ns / 100ps

module evicting_message_ring_buffer_tb;
    import emrb_pkg::*;

    localparam int unsigned RING_SIZE   = 1024;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int unsigned QUIET_LIMIT = 40000;
    localparam int unsigned HOLD_CYCLES = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    emrb_in_if  cmd_ch ();
    emrb_out_if reply_ch ();

    evicting_message_ring_buffer #(
        .RING_BYTES(RING_SIZE)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (reply_ch)
    );

    // Commands waiting to be offered, and replies predicted but not yet seen.
    t_in_item    cmd_backlog[$];
    t_out_item   predicted_replies[$];

    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_idle_pct  = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    // Shadow copy of the ring and its pointers.
    logic [7:0]  ring_image [RING_SIZE];
    logic [9:0]  head_image;
    logic [9:0]  tail_image;
    logic [9:0]  write_image;
    logic [11:0] fill_image;
    logic [10:0] left_image;

    always #5 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Drop the oldest message plus the NUL padding behind it; returns the bytes walked.
    function automatic int unsigned evict_oldest_message();
        int unsigned walked = 0;
        int unsigned steps  = 0;
        int unsigned p      = tail_image;
        logic [7:0]  b;
        while (steps < RING_SIZE) begin
            b = ring_image[p];
            p = (p + 1) % RING_SIZE;
            walked++;
            steps++;
            if (b == 8'h00) break;
        end
        steps = 0;
        while (steps < RING_SIZE && ring_image[p] == 8'h00) begin
            p = (p + 1) % RING_SIZE;
            walked++;
            steps++;
        end
        tail_image = p[9:0];
        return walked;
    endfunction

    // A valid header pads the end of the ring if needed, then evicts until it fits.
    function automatic void open_message(input int unsigned len);
        int unsigned top = head_image;
        int unsigned walked;
        if (top + len >= RING_SIZE) begin
            for (int unsigned p = top; p < RING_SIZE; p++) ring_image[p] = 8'h00;
            fill_image = fill_image + 12'(RING_SIZE - top);
            top = 0;
        end
        while (32'(fill_image) + len >= RING_SIZE) begin
            walked = evict_oldest_message();
            fill_image = (walked >= fill_image) ? 12'd0 : fill_image - 12'(walked);
        end
        head_image  = top[9:0];
        write_image = top[9:0];
        left_image  = len[10:0];
    endfunction

    // Apply one command to the shadow ring and return the reply it should produce.
    function automatic t_out_item model_command(input t_in_item it);
        t_out_item res;
        res = '0;
        case (it.cmd)
            CMD_HEADER: begin
                if (it.msg_len <= 16'd1 || 32'(it.msg_len) >= RING_SIZE) begin
                    left_image = '0;
                    res.status = ST_REJECT;
                end else begin
                    open_message(32'(it.msg_len));
                    res.status = ST_ACCEPT;
                end
            end
            CMD_DATA: begin
                if (left_image == '0) begin
                    res.status = ST_DISCARD;
                end else begin
                    ring_image[write_image] = it.data_byte;
                    write_image = 10'((32'(write_image) + 1) % RING_SIZE);
                    head_image  = write_image;
                    fill_image  = fill_image + 12'd1;
                    left_image  = left_image - 11'd1;
                    res.status  = ST_STORED;
                end
            end
            CMD_READ: begin
                res.read_data = ring_image[32'(it.read_index) % RING_SIZE];
                res.status    = ST_READ;
            end
            default: res.status = ST_DISCARD;
        endcase
        res.head_pos   = head_image;
        res.tail_pos   = tail_image;
        res.fill_count = fill_image[9:0];
        return res;
    endfunction

    // Compare one received reply with the oldest prediction.
    task automatic check_reply(input t_out_item got);
        t_out_item want;
        if (predicted_replies.size() == 0) begin
            report_error($sformatf("reply with no command outstanding, status %0d",
                                   got.status));
        end else begin
            want = predicted_replies.pop_front();
            if (got.status !== want.status)
                report_error($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.read_data !== want.read_data)
                report_error($sformatf("read_data %0d, expected %0d",
                                       got.read_data, want.read_data));
            if (got.head_pos !== want.head_pos)
                report_error($sformatf("head_pos %0d, expected %0d",
                                       got.head_pos, want.head_pos));
            if (got.tail_pos !== want.tail_pos)
                report_error($sformatf("tail_pos %0d, expected %0d",
                                       got.tail_pos, want.tail_pos));
            if (got.fill_count !== want.fill_count)
                report_error($sformatf("fill_count %0d, expected %0d",
                                       got.fill_count, want.fill_count));
        end
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input logic [15:0] len,
                            input logic [7:0] dbyte, input logic [9:0] idx);
        t_in_item it;
        it.cmd        = cmd;
        it.msg_len    = len;
        it.data_byte  = dbyte;
        it.read_index = idx;
        cmd_backlog.push_back(it);
    endtask

    // Random traffic: mostly complete messages, plus abandoned and rejected
    // headers, reads and stray commands. Ignored commands are not counted.
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned counted = 0;
        int unsigned pick;
        int unsigned len;
        int unsigned n;
        while (counted < n_items) begin
            pick = $urandom_range(99);
            if (pick < 63) begin
                // Long messages stay within the remaining count.
                if (pick < 3 && n_items - counted > 200)
                    len = $urandom_range(200, (n_items - counted < RING_SIZE) ?
                                              n_items - counted : RING_SIZE - 1);
                else
                    len = $urandom_range(2, 40);
                push_cmd(CMD_HEADER, 16'(len), 8'($urandom), 10'($urandom));
                for (int unsigned k = 1; k < len; k++) begin
                    push_cmd(CMD_DATA, 16'($urandom),
                             ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                             10'($urandom));
                end
                push_cmd(CMD_DATA, 16'($urandom), 8'h00, 10'($urandom));
                counted += len + 1;
            end else if (pick < 75) begin
                // Header that a later header abandons after a few bytes.
                len = $urandom_range(2, RING_SIZE - 1);
                n = $urandom_range(0, (len - 1 < 8) ? len - 1 : 8);
                push_cmd(CMD_HEADER, 16'(len), 8'($urandom), 10'($urandom));
                for (int unsigned k = 0; k < n; k++)
                    push_cmd(CMD_DATA, 16'($urandom), 8'($urandom), 10'($urandom));
                counted += n + 1;
            end else if (pick < 82) begin
                case ($urandom_range(3))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = RING_SIZE;
                    default: len = $urandom_range(RING_SIZE + 1, 65535);
                endcase
                push_cmd(CMD_HEADER, 16'(len), 8'($urandom), 10'($urandom));
                n = $urandom_range(0, 3);
                for (int unsigned k = 0; k < n; k++)
                    push_cmd(CMD_DATA, 16'($urandom), 8'($urandom), 10'($urandom));
                counted += 1;
            end else if (pick < 94) begin
                push_cmd(CMD_READ, 16'($urandom), 8'($urandom),
                         10'($urandom_range(RING_SIZE - 1)));
                counted += 1;
            end else if (pick < 97) begin
                push_cmd(CMD_DATA, 16'($urandom), 8'($urandom), 10'($urandom));
            end else begin
                push_cmd(CMD_UNUSED, 16'($urandom), 8'($urandom), 10'($urandom));
            end
        end
    endtask

    // Wait until every queued command went in and every reply came back.
    task automatic wait_for_drain();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Command driver: a new item is offered only once the previous one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                cmd_ch.payload <= cmd_backlog.pop_front();
                cmd_ch.valid   <= 1'b1;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Reply receiver: random stalls, and a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reply_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            reply_ch.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served    <= hold_requests;
            hold_left      <= HOLD_CYCLES;
            reply_ch.ready <= 1'b0;
        end else begin
            reply_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: predicts on each accepted command, checks each accepted reply,
    // and ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                predicted_replies.push_back(model_command(cmd_ch.payload));
            if (reply_ch.valid && reply_ch.ready)
                check_reply(reply_ch.payload);
        end
        if ((cmd_ch.valid && cmd_ch.ready) || (reply_ch.valid && reply_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("evicting_message_ring_buffer_tb failed");
            $finish;
        end
    end

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        reply_ch.ready = 1'b0;
        for (int unsigned k = 0; k < RING_SIZE; k++) ring_image[k] = 8'h00;
        head_image  = '0;
        tail_image  = '0;
        write_image = '0;
        fill_image  = '0;
        left_image  = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: reads at both ends, stray commands, rejected lengths,
        // a short message, the longest legal header and an abandoned message.
        push_cmd(CMD_READ, 16'h0000, 8'h00, 10'd0);
        push_cmd(CMD_READ, 16'hFFFF, 8'hFF, 10'd1023);
        push_cmd(CMD_UNUSED, 16'hFFFF, 8'hFF, 10'd1023);
        push_cmd(CMD_DATA, 16'h0000, 8'hFF, 10'd0);
        push_cmd(CMD_HEADER, 16'd0, 8'h00, 10'd0);
        push_cmd(CMD_HEADER, 16'd1, 8'h00, 10'd0);
        push_cmd(CMD_HEADER, 16'(RING_SIZE), 8'h00, 10'd0);
        push_cmd(CMD_HEADER, 16'hFFFF, 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h55, 10'd0);
        push_cmd(CMD_HEADER, 16'd2, 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'hAA, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h01, 10'd0);
        push_cmd(CMD_HEADER, 16'(RING_SIZE - 1), 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h7F, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h80, 10'd0);
        push_cmd(CMD_HEADER, 16'd3, 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'hFF, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h00, 10'd0);
        push_cmd(CMD_DATA, 16'h0000, 8'h00, 10'd0);
        push_cmd(CMD_READ, 16'h0000, 8'h00, 10'd1);
        push_cmd(CMD_READ, 16'h0000, 8'h00, 10'd1022);
        wait_for_drain();

        // Sender rarely idles while the receiver mostly stalls.
        snd_idle_pct = 6;
        rcv_idle_pct = 80;
        queue_random_traffic(370);
        wait_for_drain();

        // Roles swapped.
        snd_idle_pct = 80;
        rcv_idle_pct = 6;
        queue_random_traffic(370);
        wait_for_drain();

        // Full rate, starting with a long receiver hold-off so the block backs up.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_requests++;
        queue_random_traffic(180);
        wait_for_drain();
        queue_random_traffic(180);
        wait_for_drain();

        // Let any spurious reply show up before the verdict.
        repeat (30) @(negedge i_clk);
        if (error_count == 0)
            $display("evicting_message_ring_buffer_tb passed");
        else
            $display("evicting_message_ring_buffer_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/emrb_pkg.sv
rtl/emrb_if.sv
rtl/emrb_datapath.sv
rtl/emrb_ctrl.sv
rtl/evicting_message_ring_buffer.sv
bench/evicting_message_ring_buffer_tb.sv
